// File: rtl/mvd_pkg.sv
// Shared types, codes and decode functions for the motion vector syntax decoder.
`default_nettype none

package mvd_pkg;

  localparam int WinW = 64;
  localparam int PosW = 6;
  localparam int RlenW = 4;
  localparam int ResidW = 8;
  localparam int CfgIdxW = 8;
  localparam int FcodeW = 4;

  localparam logic [1:0] ERR_OK = 2'd0;
  localparam logic [1:0] ERR_MC = 2'd1;
  localparam logic [1:0] ERR_DMV = 2'd2;

  localparam logic [CfgIdxW-1:0] REG_FWD_HORIZ = 8'd0;
  localparam logic [CfgIdxW-1:0] REG_FWD_VERT = 8'd1;
  localparam logic [CfgIdxW-1:0] REG_BWD_HORIZ = 8'd2;
  localparam logic [CfgIdxW-1:0] REG_BWD_VERT = 8'd3;

  localparam logic [1:0] MOTION_DUAL_PRIME = 2'd3;

  typedef struct packed {
    logic              hit;
    logic [3:0]        len;
    logic signed [5:0] value;
  } mc_t;

  typedef struct packed {
    logic [RlenW-1:0] horiz;
    logic [RlenW-1:0] vert;
  } rlen_pair_t;

  typedef struct packed {
    logic [1:0]        len;
    logic signed [1:0] value;
  } dmv_t;

  // Table B-10 motion_code, first stream bit in b[10]
  function automatic mc_t decode_mc(input logic [10:0] b);
    mc_t        m;
    logic [4:0] mag;
    logic       neg;
    m.hit = 1'b1;
    m.len = 4'd1;
    mag = 5'd0;
    neg = 1'b0;
    if (b[10]) begin
      m.len = 4'd1;
      mag = 5'd0;
    end else if (b[9]) begin
      m.len = 4'd3;  mag = 5'd1;  neg = b[8];
    end else if (b[8]) begin
      m.len = 4'd4;  mag = 5'd2;  neg = b[7];
    end else if (b[7]) begin
      m.len = 4'd5;  mag = 5'd3;  neg = b[6];
    end else if (b[10:5] == 6'b000011) begin
      m.len = 4'd7;  mag = 5'd4;  neg = b[4];
    end else if (b[10:4] == 7'b0000101) begin
      m.len = 4'd8;  mag = 5'd5;  neg = b[3];
    end else if (b[10:4] == 7'b0000100) begin
      m.len = 4'd8;  mag = 5'd6;  neg = b[3];
    end else if (b[10:4] == 7'b0000011) begin
      m.len = 4'd8;  mag = 5'd7;  neg = b[3];
    end else if (b[10:2] == 9'b000001011) begin
      m.len = 4'd10; mag = 5'd8;  neg = b[1];
    end else if (b[10:2] == 9'b000001010) begin
      m.len = 4'd10; mag = 5'd9;  neg = b[1];
    end else if (b[10:2] == 9'b000001001) begin
      m.len = 4'd10; mag = 5'd10; neg = b[1];
    end else if (b[10:1] == 10'b0000010001) begin
      m.len = 4'd11; mag = 5'd11; neg = b[0];
    end else if (b[10:1] == 10'b0000010000) begin
      m.len = 4'd11; mag = 5'd12; neg = b[0];
    end else if (b[10:1] == 10'b0000001111) begin
      m.len = 4'd11; mag = 5'd13; neg = b[0];
    end else if (b[10:1] == 10'b0000001110) begin
      m.len = 4'd11; mag = 5'd14; neg = b[0];
    end else if (b[10:1] == 10'b0000001101) begin
      m.len = 4'd11; mag = 5'd15; neg = b[0];
    end else if (b[10:1] == 10'b0000001100) begin
      m.len = 4'd11; mag = 5'd16; neg = b[0];
    end else begin
      m.hit = 1'b0;
      m.len = 4'd0;
    end
    m.value = neg ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    return m;
  endfunction

  // Table B-11 dmvector; covers every pattern
  function automatic dmv_t decode_dmv(input logic [1:0] b);
    dmv_t d;
    if (!b[1]) begin
      d.len = 2'd1;
      d.value = 2'sd0;
    end else begin
      d.len = 2'd2;
      d.value = b[0] ? -2'sd1 : 2'sd1;
    end
    return d;
  endfunction

  // Residual length from f_code: none for 0 or 1, saturate at eight bits
  function automatic logic [RlenW-1:0] rlen_of(input logic [FcodeW-1:0] fc);
    logic [RlenW-1:0] r;
    if (fc <= 4'd1) r = 4'd0;
    else if (fc > 4'd9) r = 4'd8;
    else r = fc - 4'd1;
    return r;
  endfunction

  // Top rlen bits of an eight-bit slice, zero when rlen is zero
  function automatic logic [ResidW-1:0] take_resid(input logic [ResidW-1:0] top,
                                                   input logic [RlenW-1:0] rlen);
    logic [ResidW-1:0] v;
    if (rlen == 4'd0) v = '0;
    else v = top >> (4'd8 - rlen);
    return v;
  endfunction

endpackage

`default_nettype wire

// File: rtl/mvd_fcode_regs.sv
// f_code register file with residual length selection by direction.
`default_nettype none

module mvd_fcode_regs
  import mvd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               wr_en,
  input  wire logic [CfgIdxW-1:0] wr_index,
  input  wire logic [FcodeW-1:0]  wr_data,
  input  wire logic               dir,
  output rlen_pair_t              rlen
);

  logic [FcodeW-1:0] fwd_horiz;
  logic [FcodeW-1:0] fwd_vert;
  logic [FcodeW-1:0] bwd_horiz;
  logic [FcodeW-1:0] bwd_vert;

  always_ff @(posedge clk) begin
    if (rst) begin
      fwd_horiz <= 4'd1;
      fwd_vert <= 4'd1;
      bwd_horiz <= 4'd1;
      bwd_vert <= 4'd1;
    end else if (wr_en) begin
      case (wr_index)
        REG_FWD_HORIZ: fwd_horiz <= wr_data;
        REG_FWD_VERT: fwd_vert <= wr_data;
        REG_BWD_HORIZ: bwd_horiz <= wr_data;
        REG_BWD_VERT: bwd_vert <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    rlen.horiz = rlen_of(dir ? bwd_horiz : fwd_horiz);
    rlen.vert = rlen_of(dir ? bwd_vert : fwd_vert);
  end

endmodule

`default_nettype wire

// File: rtl/mpeg2_motion_vector_syntax_decoder_top.sv
// Pipelined decoder for one MPEG-2 motion_vector(r,s) per 64-bit stream window.
//
// Input channel: bit_window (first stream bit in bit 63), vector_index, direction
// and both motion types, taken when in_valid is high and in_stall is low.
// Output channel: decoded codes, residuals, dmvectors, bits_used and
// error_code, taken when out_valid is high and out_stall is low.
// Config channel: cfg_index 0..3 selects an f_code register, cfg_data is
// written when cfg_valid and cfg_ready are high; cfg_ready is always high and
// other indices are ignored. Write only while no item is in flight.
// Four register stages: horizontal motion_code, horizontal residual, horizontal
// dmvector plus vertical motion_code, then vertical residual and dmvector into
// the output register. A result is registered in s1, s2 and s3 before it is
// presented; one item a cycle is sustained while no result waits under out_stall,
// the stage depth set by the VLC decode and window shifters.
// The whole pipeline advances together: while a result waits under out_stall,
// in_stall is raised and every stage holds.
// Synchronous reset empties the pipeline and sets every f_code to 1.
`default_nettype none

module mpeg2_motion_vector_syntax_decoder_top
  import mvd_pkg::*;
(
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [WinW-1:0]    bit_window,
  input  wire logic               vector_index,
  input  wire logic               direction,
  input  wire logic [1:0]         frame_motion_kind,
  input  wire logic [1:0]         field_motion_kind,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    vector_index_out,
  output logic                    direction_out,
  output logic signed [5:0]       horiz_code,
  output logic [ResidW-1:0]       horiz_residual,
  output logic signed [1:0]       horiz_dual_prime,
  output logic signed [5:0]       vert_code,
  output logic [ResidW-1:0]       vert_residual,
  output logic signed [1:0]       vert_dual_prime,
  output logic [PosW-1:0]         bits_used,
  output logic [1:0]              error_code,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [CfgIdxW-1:0] cfg_index,
  input  wire logic [FcodeW-1:0]  cfg_data
);

  logic       advance;
  rlen_pair_t rlen_in;

  assign advance = !(out_valid && out_stall);
  assign in_stall = !advance;
  assign cfg_ready = 1'b1;

  mvd_fcode_regs u_fcode (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .dir      (direction),
    .rlen     (rlen_in)
  );

  // Stage 1: horizontal motion_code
  logic            s1_valid;
  logic [WinW-1:0] s1_win;
  logic            s1_r;
  logic            s1_s;
  logic            s1_dual;
  rlen_pair_t      s1_rlen;
  mc_t             s1_mc;

  always_ff @(posedge clk) begin
    if (rst) s1_valid <= 1'b0;
    else if (advance) s1_valid <= in_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s1_win <= bit_window;
      s1_r <= vector_index;
      s1_s <= direction;
      s1_dual <= (frame_motion_kind == MOTION_DUAL_PRIME) ||
                 (field_motion_kind == MOTION_DUAL_PRIME);
      s1_rlen <= rlen_in;
      s1_mc <= decode_mc(bit_window[WinW-1 -: 11]);
    end
  end

  // Stage 2: horizontal residual, realign window past it
  logic [RlenW-1:0] s1_ru;
  logic [4:0]       s1_shift;
  logic [WinW-1:0]  s1_after_code;

  assign s1_ru = (s1_mc.hit && s1_mc.value != 6'sd0) ? s1_rlen.horiz : '0;
  assign s1_shift = {1'b0, s1_mc.len} + {1'b0, s1_ru};
  assign s1_after_code = s1_win << s1_mc.len;

  logic                s2_valid;
  logic [WinW-1:0]     s2_win;
  logic [PosW-1:0]     s2_pos;
  logic                s2_err;
  logic signed [5:0]   s2_code;
  logic [ResidW-1:0]   s2_resid;
  logic                s2_r;
  logic                s2_s;
  logic                s2_dual;
  logic [RlenW-1:0]    s2_rlen_v;

  always_ff @(posedge clk) begin
    if (rst) s2_valid <= 1'b0;
    else if (advance) s2_valid <= s1_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s2_win <= s1_win << s1_shift;
      s2_pos <= {1'b0, s1_shift};
      s2_err <= !s1_mc.hit;
      s2_code <= s1_mc.hit ? s1_mc.value : 6'sd0;
      s2_resid <= take_resid(s1_after_code[WinW-1 -: ResidW], s1_ru);
      s2_r <= s1_r;
      s2_s <= s1_s;
      s2_dual <= s1_dual;
      s2_rlen_v <= s1_rlen.vert;
    end
  end

  // Stage 3: horizontal dmvector, then vertical motion_code
  dmv_t            s2_dmv;
  logic [1:0]      s2_dlen;
  logic [WinW-1:0] s2_after_dmv;

  assign s2_dmv = decode_dmv(s2_win[WinW-1 -: 2]);
  assign s2_dlen = s2_dual ? s2_dmv.len : 2'd0;
  assign s2_after_dmv = s2_win << s2_dlen;

  logic                s3_valid;
  logic [WinW-1:0]     s3_win;
  logic [PosW-1:0]     s3_pos;
  logic                s3_err;
  logic signed [5:0]   s3_code;
  logic [ResidW-1:0]   s3_resid;
  logic signed [1:0]   s3_dmv;
  mc_t                 s3_mc;
  logic                s3_r;
  logic                s3_s;
  logic                s3_dual;
  logic [RlenW-1:0]    s3_rlen_v;

  always_ff @(posedge clk) begin
    if (rst) s3_valid <= 1'b0;
    else if (advance) s3_valid <= s2_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      s3_win <= s2_after_dmv;
      s3_pos <= s2_pos + {4'd0, s2_dlen};
      s3_err <= s2_err;
      s3_code <= s2_code;
      s3_resid <= s2_resid;
      s3_dmv <= s2_dual ? s2_dmv.value : 2'sd0;
      s3_mc <= decode_mc(s2_after_dmv[WinW-1 -: 11]);
      s3_r <= s2_r;
      s3_s <= s2_s;
      s3_dual <= s2_dual;
      s3_rlen_v <= s2_rlen_v;
    end
  end

  // Stage 4: vertical residual and dmvector into the output register
  logic [RlenW-1:0] s3_ru;
  logic [4:0]       s3_shift;
  logic [WinW-1:0]  s3_after_code;
  logic [WinW-1:0]  s3_after_resid;
  dmv_t             s3_vdmv;
  logic [1:0]       s3_vdlen;

  assign s3_ru = (s3_mc.hit && s3_mc.value != 6'sd0) ? s3_rlen_v : '0;
  assign s3_shift = {1'b0, s3_mc.len} + {1'b0, s3_ru};
  assign s3_after_code = s3_win << s3_mc.len;
  assign s3_after_resid = s3_win << s3_shift;
  assign s3_vdmv = decode_dmv(s3_after_resid[WinW-1 -: 2]);
  assign s3_vdlen = s3_dual ? s3_vdmv.len : 2'd0;

  always_ff @(posedge clk) begin
    if (rst) out_valid <= 1'b0;
    else if (advance) out_valid <= s3_valid;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vector_index_out <= s3_r;
      direction_out <= s3_s;
      if (s3_err) begin
        // horizontal code failed: drop everything decoded after it
        horiz_code <= 6'sd0;
        horiz_residual <= '0;
        horiz_dual_prime <= 2'sd0;
        vert_code <= 6'sd0;
        vert_residual <= '0;
        vert_dual_prime <= 2'sd0;
        bits_used <= '0;
        error_code <= ERR_MC;
      end else if (!s3_mc.hit) begin
        horiz_code <= s3_code;
        horiz_residual <= s3_resid;
        horiz_dual_prime <= s3_dmv;
        vert_code <= 6'sd0;
        vert_residual <= '0;
        vert_dual_prime <= 2'sd0;
        bits_used <= s3_pos;
        error_code <= ERR_MC;
      end else begin
        horiz_code <= s3_code;
        horiz_residual <= s3_resid;
        horiz_dual_prime <= s3_dmv;
        vert_code <= s3_mc.value;
        vert_residual <= take_resid(s3_after_code[WinW-1 -: ResidW], s3_ru);
        vert_dual_prime <= s3_dual ? s3_vdmv.value : 2'sd0;
        bits_used <= s3_pos + {1'b0, s3_shift} + {4'd0, s3_vdlen};
        error_code <= ERR_OK;
      end
    end
  end

  a_no_dmv_error: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> error_code != ERR_DMV)
    else $error("dmvector error reported");

  a_bits_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> bits_used <= 6'd42)
    else $error("bits_used beyond syntax maximum");

  a_ok_min_bits: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_OK |-> bits_used >= 6'd2)
    else $error("successful decode consumed too few bits");

  a_zero_code_no_resid: assert property (@(posedge clk) disable iff (rst)
    out_valid && horiz_code == 6'sd0 |-> horiz_residual == '0)
    else $error("residual present for zero motion_code");

  a_first_fail_clean: assert property (@(posedge clk) disable iff (rst)
    out_valid && error_code == ERR_MC && bits_used == '0 |->
      horiz_code == 6'sd0 && vert_code == 6'sd0)
    else $error("fields left after failed first motion_code");

endmodule

`default_nettype wire
